@@ rtl/core/brm_pkg.sv @@
// Shared types and codes for the byte register machine execute unit.
// No dependencies; every other file in rtl/core refers to it by scoped name.
package brm_pkg;

   // Register file depth default and machine word sizes
   localparam int REG_COUNT_DEF = 16;
   localparam int INSTR_W       = 16;
   localparam int BYTE_W        = 8;
   localparam int MEM_DEPTH     = 256;
   localparam int MEM_ADDR_W    = 8;

   // Opcodes (instruction bits 15..12)
   typedef enum logic [3:0] {
      OP_LOAD_MEM = 4'h1,
      OP_LOAD_IMM = 4'h2,
      OP_STORE    = 4'h3,
      OP_MOVE     = 4'h4,
      OP_ADD      = 4'h5,
      OP_OR       = 4'h7,
      OP_AND      = 4'h8,
      OP_XOR      = 4'h9
   } opcode_type;

   // Destination kinds reported per transaction
   localparam logic [1:0] DEST_NONE = 2'd0;
   localparam logic [1:0] DEST_REG  = 2'd1;
   localparam logic [1:0] DEST_MEM  = 2'd2;

   // Status codes
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   // One result item
   typedef struct packed {
      logic [1:0]        dest_kind;
      logic [BYTE_W-1:0] dest_index;
      logic [BYTE_W-1:0] written_value;
      logic              status;
   } result_type;

   // Write request into the data memory
   typedef struct packed {
      logic                  en;
      logic [MEM_ADDR_W-1:0] addr;
      logic [BYTE_W-1:0]     data;
   } mem_wr_type;

endpackage

@@ rtl/core/brm_if.sv @@
// Valid/ready channel interfaces for instruction and result transactions.
// Depends on brm_pkg for field widths.
interface brm_req_if;
   logic                            valid;
   logic                            ready;
   logic [brm_pkg::INSTR_W-1:0]     instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface brm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      dest_kind;
   logic [brm_pkg::BYTE_W-1:0]      dest_index;
   logic [brm_pkg::BYTE_W-1:0]      written_value;
   logic                            status;

   modport source (output valid, output dest_kind, output dest_index,
                   output written_value, output status, input ready);
   modport sink   (input valid, input dest_kind, input dest_index,
                   input written_value, input status, output ready);
endinterface

@@ rtl/core/brm_regfile.sv @@
// Register file: two registered read ports, one write port, per-entry valid bits.
// Depends on brm_pkg for the byte width.
module brm_regfile #(
   parameter int REG_COUNT = brm_pkg::REG_COUNT_DEF,
   localparam int IDX_W    = $clog2(REG_COUNT)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr_a,
   input  logic [IDX_W-1:0]           rd_addr_b,
   output logic [brm_pkg::BYTE_W-1:0] rd_data_a,
   output logic [brm_pkg::BYTE_W-1:0] rd_data_b,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [brm_pkg::BYTE_W-1:0] wr_data
);

   logic [brm_pkg::BYTE_W-1:0] mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0]       valid_ff;
   logic [brm_pkg::BYTE_W-1:0] rd_data_a_ff;
   logic [brm_pkg::BYTE_W-1:0] rd_data_b_ff;

   // Valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered reads, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= valid_ff[rd_addr_a] ? mem_ff[rd_addr_a] : '0;
         rd_data_b_ff <= valid_ff[rd_addr_b] ? mem_ff[rd_addr_b] : '0;
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/core/brm_dmem.sv @@
// Data memory: 256 bytes, one registered read port, one write port, valid bits.
// Depends on brm_pkg for sizes and the write request struct.
module brm_dmem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [brm_pkg::MEM_ADDR_W-1:0] rd_addr,
   output logic [brm_pkg::BYTE_W-1:0]     rd_data,
   input  brm_pkg::mem_wr_type            wr
);

   logic [brm_pkg::BYTE_W-1:0]    mem_ff [brm_pkg::MEM_DEPTH];
   logic [brm_pkg::MEM_DEPTH-1:0] valid_ff;
   logic [brm_pkg::BYTE_W-1:0]    rd_data_ff;

   // Valid bits cleared at reset stand in for the zeroed contents
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Storage write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/brm_alu.sv @@
// Instruction decode and byte ALU: forms the result item from operands.
// Depends on brm_pkg for opcodes, destination codes and the result struct.
module brm_alu (
   input  logic [brm_pkg::INSTR_W-1:0] instruction,
   input  logic [brm_pkg::BYTE_W-1:0]  opa,
   input  logic [brm_pkg::BYTE_W-1:0]  opb,
   input  logic [brm_pkg::BYTE_W-1:0]  mem_data,
   output brm_pkg::result_type         result
);

   logic [3:0]                 nib_r;
   logic [3:0]                 nib_t;
   logic [brm_pkg::BYTE_W-1:0] xy;

   assign nib_r = instruction[11:8];
   assign nib_t = instruction[3:0];
   assign xy    = instruction[7:0];

   // Decode and execute
   always_comb begin
      result.dest_kind     = brm_pkg::DEST_REG;
      result.dest_index    = {4'b0, nib_r};
      result.written_value = '0;
      result.status        = brm_pkg::STATUS_OK;
      case (instruction[15:12])
         brm_pkg::OP_LOAD_MEM: result.written_value = mem_data;
         brm_pkg::OP_LOAD_IMM: result.written_value = xy;
         brm_pkg::OP_STORE: begin
            result.dest_kind     = brm_pkg::DEST_MEM;
            result.dest_index    = xy;
            result.written_value = opa;
         end
         brm_pkg::OP_MOVE: begin
            result.dest_index    = {4'b0, nib_t};
            result.written_value = opa;
         end
         brm_pkg::OP_ADD:   result.written_value = opa + opb;  // wraps mod 256
         brm_pkg::OP_OR:    result.written_value = opa | opb;
         brm_pkg::OP_AND:   result.written_value = opa & opb;
         brm_pkg::OP_XOR:   result.written_value = opa ^ opb;
         default: begin
            result.dest_kind  = brm_pkg::DEST_NONE;
            result.dest_index = '0;
            result.status     = brm_pkg::STATUS_UNSUPPORTED;
         end
      endcase
   end

endmodule

@@ rtl/core/byte_register_machine_execute_unit.sv @@
// Top level of the byte register machine execute unit.
// Depends on brm_pkg, brm_if, brm_regfile, brm_dmem and brm_alu.
//
// Usage:
//   req_ch carries one 16-bit instruction per transaction; rsp_ch returns
//   exactly one result per instruction, in order: destination kind, index,
//   written value and status. Both channels transfer on valid && ready.
//   The result passes from the execute stage into the output register and,
//   with the receiver ready, transfers from there. Throughput is one
//   instruction per cycle while the receiver keeps up: the register file
//   (two read ports) and data memory (one read port) are read at the
//   accepting edge, the next stage executes and writes back, and a write
//   made at the same edge as a younger read is forwarded to it.
//   An output register parts the channels, so a new instruction is taken
//   while a result waits, up to one instruction in execute and one result
//   held. When the receiver stalls with both full, req_ch.ready drops.
//   Reset clears all registers and the data memory at once (valid bits);
//   the unit accepts instructions as soon as reset is released.
module byte_register_machine_execute_unit #(
   parameter int REG_COUNT = brm_pkg::REG_COUNT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   brm_req_if.sink  req_ch,
   brm_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(REG_COUNT);

   // Forwarding record of the write made at the edge an instruction entered
   typedef struct packed {
      logic                          reg_en;
      logic [IDX_W-1:0]              reg_idx;
      logic                          mem_en;
      logic [brm_pkg::MEM_ADDR_W-1:0] mem_addr;
      logic [brm_pkg::BYTE_W-1:0]    value;
   } fwd_type;

   logic                          accept;
   logic                          ex_fire;
   logic [brm_pkg::INSTR_W-1:0]   req_instr;
   logic [IDX_W-1:0]              rd_addr_a;
   logic [IDX_W-1:0]              rd_addr_b;
   logic [IDX_W-1:0]              ex_addr_a;
   logic [IDX_W-1:0]              ex_addr_b;
   logic [brm_pkg::BYTE_W-1:0]    rf_data_a;
   logic [brm_pkg::BYTE_W-1:0]    rf_data_b;
   logic [brm_pkg::BYTE_W-1:0]    dm_data;
   logic [brm_pkg::BYTE_W-1:0]    opa;
   logic [brm_pkg::BYTE_W-1:0]    opb;
   logic [brm_pkg::BYTE_W-1:0]    mem_op;
   brm_pkg::result_type           ex_result;
   brm_pkg::mem_wr_type           dm_wr;
   logic                          rf_wr_en;
   fwd_type                       cur_wr;

   logic                          ex_valid_ff, ex_valid_in;
   logic [brm_pkg::INSTR_W-1:0]   ex_instr_ff, ex_instr_in;
   fwd_type                       ex_fwd_ff, ex_fwd_in;
   logic                          out_valid_ff, out_valid_in;
   brm_pkg::result_type           out_ff, out_in;

   // Handshake
   assign ex_fire      = ex_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !ex_valid_ff || ex_fire;
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_instr    = req_ch.instruction;

   // Read port A: register R for a store, otherwise register S; port B is T
   function automatic logic [IDX_W-1:0] port_a_addr(logic [brm_pkg::INSTR_W-1:0] ins);
      port_a_addr = (ins[15:12] == brm_pkg::OP_STORE) ? ins[8 +: IDX_W] : ins[4 +: IDX_W];
   endfunction

   assign rd_addr_a = port_a_addr(req_instr);
   assign rd_addr_b = req_instr[0 +: IDX_W];
   assign ex_addr_a = port_a_addr(ex_instr_ff);
   assign ex_addr_b = ex_instr_ff[0 +: IDX_W];

   brm_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b),
      .wr_en     (rf_wr_en),
      .wr_addr   (ex_result.dest_index[IDX_W-1:0]),
      .wr_data   (ex_result.written_value)
   );

   brm_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_instr[brm_pkg::MEM_ADDR_W-1:0]),
      .rd_data (dm_data),
      .wr      (dm_wr)
   );

   // Forward the write that landed at the same edge as this instruction's read
   always_comb begin
      opa    = (ex_fwd_ff.reg_en && ex_fwd_ff.reg_idx == ex_addr_a) ? ex_fwd_ff.value : rf_data_a;
      opb    = (ex_fwd_ff.reg_en && ex_fwd_ff.reg_idx == ex_addr_b) ? ex_fwd_ff.value : rf_data_b;
      mem_op = (ex_fwd_ff.mem_en &&
                ex_fwd_ff.mem_addr == ex_instr_ff[brm_pkg::MEM_ADDR_W-1:0])
               ? ex_fwd_ff.value : dm_data;
   end

   brm_alu u_alu (
      .instruction (ex_instr_ff),
      .opa         (opa),
      .opb         (opb),
      .mem_data    (mem_op),
      .result      (ex_result)
   );

   // Write back when the executing instruction moves to the output register
   always_comb begin
      rf_wr_en         = ex_fire && (ex_result.dest_kind == brm_pkg::DEST_REG);
      dm_wr.en         = ex_fire && (ex_result.dest_kind == brm_pkg::DEST_MEM);
      dm_wr.addr       = ex_result.dest_index;
      dm_wr.data       = ex_result.written_value;
      cur_wr.reg_en    = rf_wr_en;
      cur_wr.reg_idx   = ex_result.dest_index[IDX_W-1:0];
      cur_wr.mem_en    = dm_wr.en;
      cur_wr.mem_addr  = ex_result.dest_index;
      cur_wr.value     = ex_result.written_value;
   end

   // Next state of execute stage and output register
   always_comb begin
      ex_valid_in  = ex_valid_ff;
      ex_instr_in  = ex_instr_ff;
      ex_fwd_in    = ex_fwd_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (ex_fire) begin
         ex_valid_in = 1'b0;
      end
      if (accept) begin
         ex_valid_in = 1'b1;
         ex_instr_in = req_instr;
         ex_fwd_in   = cur_wr;
      end
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (ex_fire) begin
         out_valid_in = 1'b1;
         out_in       = ex_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
      end
      ex_instr_ff <= ex_instr_in;
      ex_fwd_ff   <= ex_fwd_in;
      out_ff      <= out_in;
   end

   // Result channel
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.dest_kind     = out_ff.dest_kind;
   assign rsp_ch.dest_index    = out_ff.dest_index;
   assign rsp_ch.written_value = out_ff.written_value;
   assign rsp_ch.status        = out_ff.status;

endmodule

@@ rtl/core/brm_checker.sv @@
// Port-level checker for the execute unit, bound to the top level.
// Depends on brm_pkg for destination and status codes.
module brm_checker #(
   parameter int REG_COUNT = brm_pkg::REG_COUNT_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_dest_kind,
   input logic [brm_pkg::BYTE_W-1:0] rsp_dest_index,
   input logic [brm_pkg::BYTE_W-1:0] rsp_written_value,
   input logic                       rsp_status
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_kind) &&
         $stable(rsp_dest_index) && $stable(rsp_written_value) && $stable(rsp_status))
      else $error("stalled result transaction changed");

   // Reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Unsupported opcodes write nothing and report zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brm_pkg::STATUS_UNSUPPORTED |->
         rsp_dest_kind == brm_pkg::DEST_NONE && rsp_dest_index == '0 &&
         rsp_written_value == '0)
      else $error("unsupported opcode reported a write");

   // Executed instructions always write something
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brm_pkg::STATUS_OK |->
         rsp_dest_kind == brm_pkg::DEST_REG || rsp_dest_kind == brm_pkg::DEST_MEM)
      else $error("executed instruction without destination");

   // A register destination lies inside the register file
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_kind == brm_pkg::DEST_REG |->
         rsp_dest_index < brm_pkg::BYTE_W'(REG_COUNT))
      else $error("register index out of range");

endmodule

bind byte_register_machine_execute_unit brm_checker #(.REG_COUNT(REG_COUNT)) u_brm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_dest_kind     (rsp_ch.dest_kind),
   .rsp_dest_index    (rsp_ch.dest_index),
   .rsp_written_value (rsp_ch.written_value),
   .rsp_status        (rsp_ch.status)
);
